// ===== rtl/core/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, segment durations and the blink pattern ROM for the LED
// blink-code sequencer.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int SEG_IDX_BITS = 4;
   localparam int DUR_BITS     = 12;

   // Operation codes carried in req_tuser
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SELECT = 1'b1;

   // Mode codes
   localparam logic [1:0] MODE_NORMAL     = 2'd0;
   localparam logic [1:0] MODE_WIFI_CONN  = 2'd1;
   localparam logic [1:0] MODE_WIFI_ERR   = 2'd2;
   localparam logic [1:0] MODE_DATA_ERR   = 2'd3;

   // Segment durations in ms
   localparam logic [DUR_BITS-1:0] SHORT_MS      = 12'd200;
   localparam logic [DUR_BITS-1:0] LONG_MS       = 12'd600;
   localparam logic [DUR_BITS-1:0] PAUSE_MS      = 12'd1200;
   localparam logic [DUR_BITS-1:0] NORMAL_MS     = 12'd1500;
   localparam logic [DUR_BITS-1:0] DATA_PAUSE_MS = 12'd3000;

   // Register addresses (byte)
   localparam logic [2:0] ADDR_ACTIVE_LEVEL   = 3'd0;
   localparam logic [2:0] ADDR_INACTIVE_LEVEL = 3'd4;

   typedef struct packed {
      logic active_level;
      logic inactive_level;
   } levels_type;

   typedef struct packed {
      logic       advanced;
      logic [3:0] segment_number;
      logic       led_on;
      logic       pin_level;
   } rsp_type;

   typedef struct packed {
      logic [DUR_BITS-1:0] dur;
      logic                on;
   } seg_type;

   function automatic logic [SEG_IDX_BITS-1:0] seg_count(input logic [1:0] mode);
      logic [SEG_IDX_BITS-1:0] cnt;
      unique case (mode)
         MODE_NORMAL:    cnt = 4'd2;
         MODE_WIFI_CONN: cnt = 4'd4;
         MODE_WIFI_ERR:  cnt = 4'd9;
         MODE_DATA_ERR:  cnt = 4'd7;
         default:        cnt = 4'd2;
      endcase
      return cnt;
   endfunction

   // Entries past a pattern's end are never reached; they read as zero
   function automatic seg_type seg_rom(input logic [1:0] mode,
                                       input logic [SEG_IDX_BITS-1:0] idx);
      seg_type s;
      s = '{dur: '0, on: 1'b0};
      unique case (mode)
         MODE_NORMAL: begin
            unique case (idx)
               4'd0:    s = '{dur: NORMAL_MS, on: 1'b1};
               4'd1:    s = '{dur: NORMAL_MS, on: 1'b0};
               default: s = '{dur: '0, on: 1'b0};
            endcase
         end
         MODE_WIFI_CONN: begin
            unique case (idx)
               4'd0:    s = '{dur: SHORT_MS, on: 1'b1};
               4'd1:    s = '{dur: SHORT_MS, on: 1'b0};
               4'd2:    s = '{dur: SHORT_MS, on: 1'b1};
               4'd3:    s = '{dur: LONG_MS,  on: 1'b0};
               default: s = '{dur: '0, on: 1'b0};
            endcase
         end
         MODE_WIFI_ERR: begin
            unique case (idx)
               4'd0:    s = '{dur: SHORT_MS, on: 1'b1};
               4'd1:    s = '{dur: SHORT_MS, on: 1'b0};
               4'd2:    s = '{dur: SHORT_MS, on: 1'b1};
               4'd3:    s = '{dur: SHORT_MS, on: 1'b0};
               4'd4:    s = '{dur: LONG_MS,  on: 1'b1};
               4'd5:    s = '{dur: LONG_MS,  on: 1'b0};
               4'd6:    s = '{dur: LONG_MS,  on: 1'b1};
               4'd7:    s = '{dur: LONG_MS,  on: 1'b0};
               4'd8:    s = '{dur: PAUSE_MS, on: 1'b0};
               default: s = '{dur: '0, on: 1'b0};
            endcase
         end
         MODE_DATA_ERR: begin
            unique case (idx)
               4'd0:    s = '{dur: SHORT_MS,      on: 1'b1};
               4'd1:    s = '{dur: SHORT_MS,      on: 1'b0};
               4'd2:    s = '{dur: LONG_MS,       on: 1'b1};
               4'd3:    s = '{dur: LONG_MS,       on: 1'b0};
               4'd4:    s = '{dur: LONG_MS,       on: 1'b1};
               4'd5:    s = '{dur: LONG_MS,       on: 1'b0};
               4'd6:    s = '{dur: DATA_PAUSE_MS, on: 1'b0};
               default: s = '{dur: '0, on: 1'b0};
            endcase
         end
         default: s = '{dur: '0, on: 1'b0};
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/lbc_csr.sv =====
// ----------------------------------------------------------------------------
// lbc_csr
// APB-style register block holding the active and inactive pin levels.
// ----------------------------------------------------------------------------
module lbc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output lbc_pkg::levels_type  levels
);
   import lbc_pkg::*;

   logic       wr_en;
   logic       active_ff, active_in;
   logic       inactive_ff, inactive_in;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // paddr[2] picks the register; low bits are ignored
   always_comb begin
      active_in   = active_ff;
      inactive_in = inactive_ff;
      if (wr_en) begin
         if (csr_paddr[2] == ADDR_INACTIVE_LEVEL[2]) begin
            inactive_in = csr_pwdata[0];
         end else begin
            active_in = csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b1;
         inactive_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         inactive_ff <= inactive_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == ADDR_INACTIVE_LEVEL[2]) ?
                       {31'd0, inactive_ff} : {31'd0, active_ff};

   assign levels.active_level   = active_ff;
   assign levels.inactive_level = inactive_ff;

endmodule

// ===== rtl/core/led_blink_code_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_blink_code_sequencer
// Status LED blink-code generator with four fixed patterns.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction per item. req_tuser[0] is the op (0 = 1 ms
//    tick, 1 = mode select), req_tdata[1:0] the mode for a select.
//  - rsp channel: exactly one result transaction per request, in order.
//  - csr port: APB-style; active_level at 0x0, inactive_level at 0x4.
//    Write only while the block is idle.
// Result: registered, shown on rsp in the cycle after its request is taken.
// Throughput: one item per cycle, limited only by the single result register.
// A tick or select updates the elapsed counter and segment index in the
// same cycle it is accepted; the pattern ROM is a small constant lookup.
// Reset: no pattern runs; ticks do nothing and the pin reads inactive until
// the first select. Levels reset to active = 1, inactive = 0.
// Stall: when rsp is held off, the result register keeps its transaction and
// req_tready drops until it is taken; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module led_blink_code_sequencer #(
   parameter int ELAPSED_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] mode, [7:2] zero
   input  logic [0:0]  req_tuser,   // [0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] pin_level, [1] led_on,
                                    // [5:2] segment_number, [6] advanced, [7] zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lbc_pkg::*;

   levels_type levels;

   lbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .levels      (levels)
   );

   // sequencer state
   logic [ELAPSED_BITS-1:0] elapsed_ff, elapsed_in;
   logic [SEG_IDX_BITS-1:0] seg_idx_ff, seg_idx_in;
   logic [1:0]              mode_ff, mode_in;
   logic                    running_ff, running_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic                    op;
   logic [1:0]              req_mode;
   logic [SEG_IDX_BITS-1:0] cnt_cur;
   logic [SEG_IDX_BITS-1:0] idx_cur;
   logic [SEG_IDX_BITS-1:0] idx_next;
   logic [SEG_IDX_BITS-1:0] cnt_new;
   logic [SEG_IDX_BITS-1:0] idx_show;
   logic [ELAPSED_BITS-1:0] elapsed_inc;
   seg_type                 seg_cur;
   seg_type                 seg_new;
   logic                    adv;
   logic                    led_on;

   // result register frees up when empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign op         = req_tuser[0];
   assign req_mode   = req_tdata[1:0];

   // current segment, guarded against an out-of-pattern index
   assign cnt_cur     = seg_count(mode_ff);
   assign idx_cur     = (seg_idx_ff >= cnt_cur) ? '0 : seg_idx_ff;
   assign seg_cur     = seg_rom(mode_ff, idx_cur);
   assign idx_next    = (SEG_IDX_BITS'(idx_cur + 4'd1) >= cnt_cur) ?
                        '0 : SEG_IDX_BITS'(idx_cur + 4'd1);
   // saturating ms counter
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff :
                        elapsed_ff + ELAPSED_BITS'(1);

   always_comb begin
      elapsed_in = elapsed_ff;
      seg_idx_in = seg_idx_ff;
      mode_in    = mode_ff;
      running_in = running_ff;
      adv        = 1'b0;
      if (req_accept) begin
         if (op == OP_SELECT) begin
            // reselecting the running mode is a no-op
            if (!running_ff || req_mode != mode_ff) begin
               mode_in    = req_mode;
               seg_idx_in = '0;
               elapsed_in = '0;
               running_in = 1'b1;
               adv        = 1'b1;
            end
         end else if (running_ff) begin
            if (elapsed_inc >= ELAPSED_BITS'(seg_cur.dur)) begin
               seg_idx_in = idx_next;
               elapsed_in = '0;
               adv        = 1'b1;
            end else begin
               seg_idx_in = idx_cur;
               elapsed_in = elapsed_inc;
            end
         end
      end
   end

   // what the pin shows after this item
   assign cnt_new  = seg_count(mode_in);
   assign idx_show = (seg_idx_in >= cnt_new) ? '0 : seg_idx_in;
   assign seg_new  = seg_rom(mode_in, idx_show);
   assign led_on   = running_in && seg_new.on;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.pin_level      = led_on ? levels.active_level :
                                               levels.inactive_level;
         rsp_data_in.led_on         = led_on;
         rsp_data_in.segment_number = running_in ? seg_idx_in : '0;
         rsp_data_in.advanced       = adv;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         seg_idx_ff   <= '0;
         mode_ff      <= MODE_NORMAL;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         elapsed_ff   <= elapsed_in;
         seg_idx_ff   <= seg_idx_in;
         mode_ff      <= mode_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // idle sequencer keeps its counters cleared
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (elapsed_ff == '0 && seg_idx_ff == '0))
      else $error("idle sequencer has non-zero counters");

   // segment index stays inside the running pattern
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      seg_idx_ff < seg_count(mode_ff))
      else $error("segment index outside pattern");

   // elapsed time never reaches the segment duration without advancing
   a_elapsed_range: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (elapsed_ff < ELAPSED_BITS'(seg_rom(mode_ff, seg_idx_ff).dur)))
      else $error("elapsed time at or past segment duration");

   // an advancing item leaves the elapsed counter cleared
   a_adv_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && adv) |=> (elapsed_ff == '0))
      else $error("advance did not clear elapsed time");

   // an accepted item always loads the result register
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

endmodule

// ===== tb/lbc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbc_checker
// Watches the request, result and register ports of the blink-code sequencer.
// It keeps its own copy of the pattern state and levels, works out the
// expected result of every accepted request and compares each accepted
// result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module lbc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] mode, [7:2] zero
   input  logic [0:0]  req_tuser,   // [0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] pin_level, [1] led_on,
                                    // [5:2] segment_number, [6] advanced, [7] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          awaiting_count
);
   import lbc_pkg::*;

   localparam int MS_BITS = 12;

   logic [MS_BITS-1:0] ms_count = '0;
   logic [3:0]         step_idx = '0;
   logic [1:0]         run_mode = MODE_NORMAL;
   logic               running  = 1'b0;
   levels_type         level_cfg = '{active_level: 1'b1, inactive_level: 1'b0};
   rsp_type            expected_blink_q[$];
   int                 mismatches = 0;

   function automatic logic [3:0] pattern_length(input logic [1:0] mode);
      case (mode)
         MODE_NORMAL:    return 4'd2;
         MODE_WIFI_CONN: return 4'd4;
         MODE_WIFI_ERR:  return 4'd9;
         default:        return 4'd7;
      endcase
   endfunction

   // Even steps are lit except the closing pauses of the two error codes
   function automatic seg_type pattern_step(input logic [1:0] mode, input logic [3:0] idx);
      seg_type s;
      s = '{dur: '0, on: 1'b0};
      case (mode)
         MODE_NORMAL: begin
            s.dur = NORMAL_MS;
            s.on  = (idx == 4'd0);
         end
         MODE_WIFI_CONN: begin
            s.dur = (idx == 4'd3) ? LONG_MS : SHORT_MS;
            s.on  = ~idx[0];
         end
         MODE_WIFI_ERR: begin
            s.dur = (idx < 4'd4) ? SHORT_MS : (idx == 4'd8) ? PAUSE_MS : LONG_MS;
            s.on  = ~idx[0] && (idx != 4'd8);
         end
         MODE_DATA_ERR: begin
            s.dur = (idx < 4'd2) ? SHORT_MS : (idx == 4'd6) ? DATA_PAUSE_MS : LONG_MS;
            s.on  = ~idx[0] && (idx != 4'd6);
         end
         default: s = '{dur: '0, on: 1'b0};
      endcase
      return s;
   endfunction

   // Applies one request to the local pattern state, returns the result it gives
   function automatic rsp_type predict_blink(input logic op, input logic [1:0] mode);
      rsp_type    r;
      seg_type    s;
      logic [3:0] idx;
      r = '0;
      if (op == OP_SELECT) begin
         if (!running || mode != run_mode) begin
            run_mode   = mode;
            step_idx   = '0;
            ms_count   = '0;
            running    = 1'b1;
            r.advanced = 1'b1;
         end
      end else if (running) begin
         idx = step_idx;
         if (idx >= pattern_length(run_mode))
            idx = '0;
         if (ms_count != '1)
            ms_count = ms_count + 1'b1;
         s = pattern_step(run_mode, idx);
         if (ms_count >= s.dur) begin
            idx        = (idx + 4'd1 >= pattern_length(run_mode)) ? 4'd0 : idx + 4'd1;
            ms_count   = '0;
            r.advanced = 1'b1;
         end
         step_idx = idx;
      end
      if (running) begin
         idx = step_idx;
         if (idx >= pattern_length(run_mode))
            idx = '0;
         s = pattern_step(run_mode, idx);
         r.led_on         = s.on;
         r.segment_number = step_idx;
      end
      r.pin_level = r.led_on ? level_cfg.active_level : level_cfg.inactive_level;
      return r;
   endfunction

   function automatic void compare_field(input string label, input logic [3:0] want,
                                         input logic [3:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         expected_blink_q.delete();
         ms_count  = '0;
         step_idx  = '0;
         run_mode  = MODE_NORMAL;
         running   = 1'b0;
         level_cfg = '{active_level: 1'b1, inactive_level: 1'b0};
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[6:0];
            if (expected_blink_q.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual 0x%02h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_blink_q.pop_front();
               compare_field("pin_level", 4'(want.pin_level), 4'(got.pin_level));
               compare_field("led_on", 4'(want.led_on), 4'(got.led_on));
               compare_field("segment_number", want.segment_number, got.segment_number);
               compare_field("advanced", 4'(want.advanced), 4'(got.advanced));
               compare_field("padding", 4'd0, 4'(rsp_tdata[7]));
            end
         end
         if (req_tvalid && req_tready)
            expected_blink_q.push_back(predict_blink(req_tuser[0], req_tdata[1:0]));
         // paddr[2] picks the register, low bits are ignored
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               ADDR_ACTIVE_LEVEL[2]:   level_cfg.active_level   = csr_pwdata[0];
               ADDR_INACTIVE_LEVEL[2]: level_cfg.inactive_level = csr_pwdata[0];
               default: ;
            endcase
         end
      end
      mismatch_count <= mismatches;
      awaiting_count <= expected_blink_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Top of the blink-code sequencer bench: clock, reset, request and register
// stimulus, a randomly stalling result sink and the final verdict. All
// prediction and comparison lives in lbc_checker.
// ----------------------------------------------------------------------------
module testbench;
   import lbc_pkg::*;

   // Random part: four level settings, a small share of the items in each
   localparam int ITEMS_PER_PHASE  = 12;
   // Receiver holds off once for a long stretch so the result register fills
   localparam int LONG_HOLD_AT     = 600;
   localparam int LONG_HOLD_CYCLES = 64;
   // Worst case: about 1260 items, each waiting out the longest sender gap and
   // the longest receiver gap, plus the long hold-off once; the limit sits well
   // above that total
   localparam int LIMIT_CYCLES     = 1_000_000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [7:0]  req_tdata   = '0;   // [1:0] mode, [7:2] zero
   logic [0:0]  req_tuser   = '0;   // [0] op
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;

   logic        req_tready;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;         // [0] pin_level, [1] led_on,
                                   // [5:2] segment_number, [6] advanced, [7] zero
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int awaiting_count;
   int items_sent = 0;

   always #10 clock = ~clock;

   led_blink_code_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lbc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .awaiting_count (awaiting_count)
   );

   // Mostly back-to-back, sometimes a short gap, rarely a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75)
         return 0;
      else if (roll < 93)
         return $urandom_range(1, 2);
      else if (roll < 98)
         return $urandom_range(3, 8);
      else
         return $urandom_range(12, 40);
   endfunction

   // Offers one request transaction; called just after a rising edge. Valid is
   // only dropped when a gap follows, so a steady stream keeps it high.
   task automatic send_item(input logic op, input logic [1:0] mode, input bit steady);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, mode};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Ticks ignore the mode field, so it carries random bits
   task automatic tick_burst(input int count, input bit steady);
      logic [1:0] junk;
      repeat (count) begin
         junk = 2'($urandom_range(0, 3));
         send_item(OP_TICK, junk, steady);
      end
   endtask

   // APB write: setup phase, then access phase until pready, then back to idle
   task automatic write_level(input logic [2:0] addr, input logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {31'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Sender stops until every outstanding result has been taken. The first
   // edge lets the count catch up with a transaction accepted just before.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
   endtask

   // Result sink: random back-pressure, calm stretches with none, and one
   // long hold-off while the sender keeps offering requests
   initial begin : result_sink
      int gap;
      int taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = calm ? 0 : idle_length();
         if (taken == LONG_HOLD_AT)
            gap = LONG_HOLD_CYCLES;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken % 256 == 0)
            calm = 1'($urandom_range(0, 1));
      end
   end

   initial begin : stimulus
      int         phase_end;
      int         roll;
      int         len;
      bit         steady;
      logic       op;
      logic [1:0] mode;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset levels (active high, inactive low).
      // Ticks before any select must do nothing.
      send_item(OP_TICK, MODE_DATA_ERR, 1'b0);
      send_item(OP_TICK, MODE_NORMAL, 1'b0);
      // First select, then a reselect of the running mode (no restart)
      send_item(OP_SELECT, MODE_NORMAL, 1'b0);
      send_item(OP_SELECT, MODE_NORMAL, 1'b0);
      send_item(OP_TICK, MODE_WIFI_ERR, 1'b0);
      // Every mode code; each new mode restarts from segment 0, a reselect does not
      send_item(OP_SELECT, MODE_DATA_ERR, 1'b0);
      send_item(OP_TICK, MODE_DATA_ERR, 1'b0);
      send_item(OP_SELECT, MODE_DATA_ERR, 1'b0);
      send_item(OP_SELECT, MODE_WIFI_ERR, 1'b0);
      send_item(OP_SELECT, MODE_WIFI_CONN, 1'b0);
      // Full wifi-connecting cycle: each segment lasts exactly its duration,
      // then the pattern wraps to segment 0 and runs one tick into it.
      // The long result hold-off lands in the middle of this run.
      tick_burst(1201, 1'b0);
      send_item(OP_SELECT, MODE_WIFI_CONN, 1'b0);
      send_item(OP_SELECT, MODE_NORMAL, 1'b0);
      wait_drained();

      // Random part over four level settings: inverted, both high, both low,
      // back to the reset values. Levels are only written with nothing pending.
      for (int phase = 0; phase < 4; phase++) begin
         write_level(ADDR_ACTIVE_LEVEL, phase[0]);
         write_level(ADDR_INACTIVE_LEVEL, ~phase[1]);
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            roll   = $urandom_range(0, 99);
            steady = 1'($urandom_range(0, 1));
            mode   = 2'($urandom_range(0, 3));
            if (roll < 15) begin
               // new mode or a reselect of the running one
               send_item(OP_SELECT, mode, steady);
            end else if (roll < 25) begin
               // stray transaction
               op = 1'($urandom_range(0, 1));
               send_item(op, mode, steady);
            end else begin
               // short tick runs, kept inside the phase's share
               len = $urandom_range(1, 8);
               if (len > phase_end - items_sent)
                  len = phase_end - items_sent;
               tick_burst(len, steady);
            end
         end
         wait_drained();
      end

      // Wait for any stray result to show up before the verdict
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && awaiting_count == 0)
         $display("led_blink_code_sequencer verification clean");
      else
         $display("led_blink_code_sequencer verification failed");
      $finish;
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("led_blink_code_sequencer verification failed");
      $finish;
   end

endmodule
